/* rtl/ieee_double_to_1750a_float_convert_top_macros.svh */
// Assertion macros for the double / 1750A converter.
`ifndef IEEE_DOUBLE_TO_1750A_FLOAT_CONVERT_TOP_MACROS_SVH
`define IEEE_DOUBLE_TO_1750A_FLOAT_CONVERT_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define D2A_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define D2A_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/d2a_pkg.sv */
// ----------------------------------------------------------------------------
// d2a_pkg
// Commands, sentinel words and shared helpers for the converter.
// ----------------------------------------------------------------------------
package d2a_pkg;

    typedef enum logic [1:0] {
        CMD_ENC32 = 2'd0,
        CMD_ENC16 = 2'd1,
        CMD_DEC32 = 2'd2,
        CMD_DEC16 = 2'd3
    } cmd_t;

    localparam logic [31:0] ENC32_NAN  = 32'h7F80_0001;
    localparam logic [31:0] ENC32_PINF = 32'h7F80_0000;
    localparam logic [31:0] ENC32_NINF = 32'hFF80_0000;
    localparam logic [15:0] ENC16_NAN  = 16'h7F81;
    localparam logic [15:0] ENC16_PINF = 16'h7F80;
    localparam logic [15:0] ENC16_NINF = 16'hFF80;
    localparam logic [63:0] DBL_QNAN   = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] DBL_PINF   = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] DBL_NINF   = 64'hFFF0_0000_0000_0000;

    // Position of the highest set bit (0 for zero)
    function automatic logic [5:0] top_bit53(input logic [52:0] x);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 53; i++)
        begin
            if (x[i])
                p = 6'(i);
        end
        return p;
    endfunction

endpackage

/* rtl/d2a_encode.sv */
// ----------------------------------------------------------------------------
// d2a_encode
// Combinational double to 1750A encoder, 32-bit or 16-bit word.
// ----------------------------------------------------------------------------
module d2a_encode
    import d2a_pkg::*;
(
    input  logic        short_word,
    input  logic [63:0] operand,
    output logic [63:0] converted
);

    logic [10:0] be;
    logic [51:0] frac;
    logic        neg;
    logic [52:0] mag;
    logic [5:0]  p;
    logic        c;
    logic signed [13:0] ex;
    logic signed [13:0] e;
    logic signed [7:0]  sh;
    logic [5:0]  k;
    logic [24:0] m;
    logic [24:0] m_adj;
    logic [24:0] sm;
    logic [52:0] shifted;
    logic [4:0]  nb;

    always_comb
    begin
        be   = operand[62:52];
        frac = operand[51:0];
        neg  = operand[63];
        nb   = short_word ? 5'd9 : 5'd23;
        if (be == 11'd0)
        begin
            mag = {1'b0, frac};
            ex  = -14'sd1074;
        end
        else
        begin
            mag = {1'b1, frac};
            ex  = 14'($signed({3'b000, be})) - 14'sd1075;
        end
        p  = top_bit53(mag);
        c  = (mag != (53'd1 << p));
        e  = 14'($signed({8'd0, p})) + ex + 14'($signed({13'd0, c}));
        sh = 8'($signed({3'd0, nb})) - 8'($signed({2'd0, p})) - 8'($signed({7'd0, c}));
        k  = 6'(-sh);
        shifted = '0;
        m = '0;
        // Left shift only when value fits, else rounded right shift
        if (sh >= 0)
            m = 25'(mag << sh[4:0]);
        else
        begin
            shifted = mag >> (k - 6'd1);
            m = 25'(shifted >> 1) + {24'd0, shifted[0]};
        end
        m_adj = m;
        e = e;
        if (!neg && m == (25'd1 << nb))
        begin
            m_adj = m >> 1;
            e = e + 14'sd1;
        end
        sm = neg ? 25'(-m_adj) : m_adj;

        converted = '0;
        if (be == 11'h7FF)
        begin
            if (frac != '0)
                converted = short_word ? {48'd0, ENC16_NAN} : {32'd0, ENC32_NAN};
            else if (neg)
                converted = short_word ? {48'd0, ENC16_NINF} : {32'd0, ENC32_NINF};
            else
                converted = short_word ? {48'd0, ENC16_PINF} : {32'd0, ENC32_PINF};
        end
        else if (be == 11'd0 && frac == '0)
            converted = '0;
        else if (short_word)
            converted = {48'd0, sm[9:0], e[5:0]};
        else
            converted = {32'd0, sm[23:0], e[7:0]};
    end

endmodule

/* rtl/d2a_decode.sv */
// ----------------------------------------------------------------------------
// d2a_decode
// Combinational 1750A to double decoder, 32-bit or 16-bit word.
// ----------------------------------------------------------------------------
module d2a_decode
    import d2a_pkg::*;
(
    input  logic        short_word,
    input  logic [63:0] operand,
    output logic [63:0] converted
);

    logic [31:0] w;
    logic [30:0] low;
    logic        sgn;
    logic signed [23:0] mant;
    logic signed [9:0]  xe;
    logic [23:0] a;
    logic [5:0]  p;
    logic [51:0] fr;
    logic [10:0] bexp;

    always_comb
    begin
        if (short_word)
        begin
            w    = {16'd0, operand[15:0]};
            low  = {16'd0, operand[14:0]};
            sgn  = operand[15];
            mant = 24'($signed(operand[15:6]));
            xe   = 10'($signed(operand[5:0])) - 10'sd9;
        end
        else
        begin
            w    = operand[31:0];
            low  = operand[30:0];
            sgn  = operand[31];
            mant = $signed(operand[31:8]);
            xe   = 10'($signed(operand[7:0])) - 10'sd23;
        end
        a    = mant[23] ? 24'(-mant) : 24'(mant);
        p    = top_bit53({29'd0, a});
        fr   = 52'({28'd0, a} << (6'd52 - p));
        bexp = 11'(11'(p) + 11'($signed(xe)) + 11'd1023);

        // Zero word first, then sentinels; the sentinel match ignores the sign bit
        if (w == '0)
            converted = '0;
        else if (short_word ? (low == 31'(ENC16_NAN)) : (low == 31'(ENC32_NAN)))
            converted = DBL_QNAN;
        else if (short_word ? (low == 31'(ENC16_PINF)) : (low == 31'(ENC32_PINF)))
            converted = sgn ? DBL_NINF : DBL_PINF;
        else if (mant == '0)
            converted = '0;
        else
            converted = {mant[23], bexp, fr};
    end

endmodule

/* rtl/ieee_double_to_1750a_float_convert_top.sv */
// ----------------------------------------------------------------------------
// ieee_double_to_1750a_float_convert_top
// Double / 1750A float converter, one word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// channel | signals                            | transfer when
// in      | in_valid in_ready command operand  | in_valid & in_ready
// out     | out_valid out_ready converted      | out_valid & out_ready
//
// Input register, one conversion pass, result register.
// A new word is taken every cycle while the result stage drains or is empty.
// Reset clears both stage valid flags; payload registers are not reset.
// Stalls at the output back up into the input register and then in_ready.
// ----------------------------------------------------------------------------
`include "ieee_double_to_1750a_float_convert_top_macros.svh"

module ieee_double_to_1750a_float_convert_top
    import d2a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [63:0] operand,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] converted
);

    logic        s1_vld_reg;
    logic [1:0]  s1_cmd_reg;
    logic [63:0] s1_op_reg;
    logic        s2_vld_reg;
    logic [63:0] s2_res_reg;
    logic [63:0] enc_res;
    logic [63:0] dec_res;
    logic [63:0] s2_res_next;
    logic        s1_adv;

    // Pipeline advance
    assign s1_adv   = s1_vld_reg && (!s2_vld_reg || out_ready);
    assign in_ready = !s1_vld_reg || s1_adv;

    d2a_encode u_enc (
        .short_word (s1_cmd_reg == CMD_ENC16),
        .operand    (s1_op_reg),
        .converted  (enc_res)
    );

    d2a_decode u_dec (
        .short_word (s1_cmd_reg == CMD_DEC16),
        .operand    (s1_op_reg),
        .converted  (dec_res)
    );

    assign s2_res_next = s1_cmd_reg[1] ? dec_res : enc_res;

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_vld_reg <= in_valid;
            if (s1_adv)
                s2_vld_reg <= 1'b1;
            else if (out_ready)
                s2_vld_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_cmd_reg <= command;
            s1_op_reg  <= operand;
        end
        if (s1_adv)
            s2_res_reg <= s2_res_next;
    end

    assign out_valid = s2_vld_reg;
    assign converted = s2_res_reg;

    `D2A_ASSERT_NXT(a_s1_to_s2, clk, rst_n, s1_adv, s2_vld_reg, "advance lost item")
    `D2A_ASSERT_IMP(a_ready_full, clk, rst_n, s1_vld_reg && s2_vld_reg && !out_ready, !in_ready, "ready while full")
    `D2A_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, $stable(converted), "result changed under stall")

endmodule

/* test/ieee_double_to_1750a_float_convert_checker.sv */
// ----------------------------------------------------------------------------
// ieee_double_to_1750a_float_convert_checker
// Watches both channels of the converter, computes the expected word for each
// input transfer and compares it with each output transfer in order.
// ----------------------------------------------------------------------------
module ieee_double_to_1750a_float_convert_checker
    import d2a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  command,
    input  logic [63:0] operand,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] converted,
    output int          mismatch_count,
    output int          words_pending
);

    localparam logic [63:0] FRAC_BITS = 64'h000F_FFFF_FFFF_FFFF;

    logic [63:0] expected_words[$];

    // Highest set bit position of a nonzero value
    function automatic int msb_index(input logic [63:0] x);
        int p;
        p = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (x[i])
                p = i;
        end
        return p;
    endfunction

    // Sign extension of the low w bits
    function automatic longint sign_ext(input logic [63:0] v, input int w);
        logic [63:0] half;
        half = 64'd1 << (w - 1);
        v = v & ((half << 1) - 64'd1);
        if ((v & half) != 0)
            return longint'(v) - longint'(half << 1);
        return longint'(v);
    endfunction

    // Double bits to 1750A word; nb mantissa scale, eb exponent width,
    // mb mantissa width
    function automatic logic [63:0] encode_1750a(
        input logic [63:0] d, input int nb, input int eb, input int mb,
        input logic [63:0] s_nan, input logic [63:0] s_pinf,
        input logic [63:0] s_ninf);
        logic [10:0] be;
        logic [51:0] f;
        logic        neg;
        logic [63:0] mag, m, sm, e_bits;
        int          ex, p, c, e, sh, k;
        be  = d[62:52];
        f   = d[51:0];
        neg = d[63];
        if (be == 11'h7FF)
            return (f != 0) ? s_nan : (neg ? s_ninf : s_pinf);
        if (be == 0 && f == 0)
            return 64'd0;
        if (be == 0)
        begin
            mag = {12'd0, f};
            ex  = -1074;
        end
        else
        begin
            mag = {11'd0, 1'b1, f};
            ex  = int'(be) - 1075;
        end
        p  = msb_index(mag);
        c  = (mag != (64'd1 << p)) ? 1 : 0;
        e  = p + ex + c;
        sh = nb - p - c;
        if (sh >= 0)
            m = mag << sh;
        else
        begin
            k = -sh;
            m = (mag >> k) + ((mag >> (k - 1)) & 64'd1);
        end
        // positive full-scale mantissa is renormalized
        if (!neg && m == (64'd1 << nb))
        begin
            m = m >> 1;
            e = e + 1;
        end
        sm     = neg ? (64'd0 - m) : m;
        e_bits = 64'(longint'(e));
        return ((sm & ((64'd1 << mb) - 64'd1)) << eb) |
               (e_bits & ((64'd1 << eb) - 64'd1));
    endfunction

    // 1750A word to double bits; wb word width
    function automatic logic [63:0] decode_1750a(
        input logic [63:0] w, input int nb, input int eb, input int wb,
        input logic [63:0] s_nan, input logic [63:0] s_inf);
        logic [63:0] wmask, low, a, frac;
        longint      x, mant;
        int          p;
        wmask = (64'd1 << wb) - 64'd1;
        w     = w & wmask;
        if (w == 0)
            return 64'd0;
        // sentinels ignore the sign bit
        low = w & (wmask >> 1);
        if (low == s_nan)
            return DBL_QNAN;
        if (low == s_inf)
            return w[wb-1] ? DBL_NINF : DBL_PINF;
        x    = sign_ext(w, eb) - nb;
        mant = sign_ext(w >> eb, wb - eb);
        if (mant == 0)
            return 64'd0;
        a    = (mant < 0) ? 64'(-mant) : 64'(mant);
        p    = msb_index(a);
        frac = (a << (52 - p)) & FRAC_BITS;
        return {(mant < 0), 11'(p + x + 1023), frac[51:0]};
    endfunction

    function automatic logic [63:0] predict_conversion(
        input cmd_t cmd, input logic [63:0] v);
        case (cmd)
            CMD_ENC32: return encode_1750a(v, 23, 8, 24, 64'(ENC32_NAN),
                                           64'(ENC32_PINF), 64'(ENC32_NINF));
            CMD_ENC16: return encode_1750a(v, 9, 6, 10, 64'(ENC16_NAN),
                                           64'(ENC16_PINF), 64'(ENC16_NINF));
            CMD_DEC32: return decode_1750a(v, 23, 8, 32, 64'(ENC32_NAN),
                                           64'(ENC32_PINF));
            default:   return decode_1750a(v, 9, 6, 16, 64'(ENC16_NAN),
                                           64'(ENC16_PINF));
        endcase
    endfunction

    assign words_pending = expected_words.size();

    // Compare output transfers, then queue the prediction for input transfers
    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0] want;
        if (!rst_n)
        begin
            mismatch_count = 0;
            expected_words.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: unexpected transfer, converted=%h", converted);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (converted !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("ERROR: converted expected %h actual %h",
                                     want, converted);
                    end
                end
            end
            if (in_valid && in_ready)
                expected_words.push_back(predict_conversion(cmd_t'(command), operand));
        end
    end

endmodule

/* test/tb_ieee_double_to_1750a_float_convert_top.sv */
// ----------------------------------------------------------------------------
// tb_ieee_double_to_1750a_float_convert_top
// Drives directed and random conversion requests with random gaps and output
// stalls, including a long output stall and a full drain; the checker
// module predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_ieee_double_to_1750a_float_convert_top;
    import d2a_pkg::*;

    localparam int RANDOM_WORDS = 630;
    localparam int CYCLE_LIMIT  = 200000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [63:0] operand;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] converted;
    int          mismatch_count;
    int          words_pending;
    int          cycle_count = 0;
    logic        no_idle;
    logic        long_stall_req;

    ieee_double_to_1750a_float_convert_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .operand   (operand),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .converted (converted)
    );

    ieee_double_to_1750a_float_convert_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .operand        (operand),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .converted      (converted),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // One input transfer, preceded by a random gap unless no_idle is set
    task automatic send_word(input cmd_t cmd, input logic [63:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        operand  <= val;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Random encode operand, biased to specials and rounding edges
    function automatic logic [63:0] rand_double();
        logic [63:0] d;
        d = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: d[62:52] = 11'h7FF;
            1: d[62:52] = 11'h000;
            2: d[51:29] = '1;
            3: d[51:43] = '1;
            4: d[51:0]  = 52'd0;
            5: d[62:52] = 11'($urandom_range(1023 - 140, 1023 + 140));
            default: ;
        endcase
        return d;
    endfunction

    // Random decode operand, biased to sentinels and zero mantissa
    function automatic logic [63:0] rand_word(input cmd_t cmd);
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: w[30:0] = (cmd == CMD_DEC32) ? ENC32_NAN[30:0] : 31'(ENC16_NAN[14:0]);
            1: w[30:0] = (cmd == CMD_DEC32) ? ENC32_PINF[30:0] : 31'(ENC16_PINF[14:0]);
            2: if (cmd == CMD_DEC32) w[31:8] = '0; else w[15:6] = '0;
            3: if (cmd == CMD_DEC32) w[31:0] = '0; else w[15:0] = '0;
            default: ;
        endcase
        return w;
    endfunction

    // Output side: random stalls, plus one long hold-off on request
    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (long_stall_req)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_stall_req = 1'b0;
            end
            n = no_idle ? 0 : $urandom_range(0, 7);
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Stimulus and verdict
    initial
    begin
        cmd_t cmd;
        int   waited;
        no_idle        = 1'b0;
        long_stall_req = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = CMD_ENC32;
        operand        = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zeros, specials, unit, subnormal, renormalization, sentinels
        send_word(CMD_ENC32, 64'h0000_0000_0000_0000);
        send_word(CMD_ENC16, 64'h8000_0000_0000_0000);
        send_word(CMD_ENC32, 64'h7FF8_0000_0000_0001);
        send_word(CMD_ENC16, 64'hFFF0_0000_0000_0001);
        send_word(CMD_ENC32, 64'h7FF0_0000_0000_0000);
        send_word(CMD_ENC16, 64'hFFF0_0000_0000_0000);
        send_word(CMD_ENC32, 64'h3FF0_0000_0000_0000);
        send_word(CMD_ENC16, 64'hBFF0_0000_0000_0000);
        send_word(CMD_ENC32, 64'h0000_0000_0000_0001);
        send_word(CMD_ENC16, 64'h800F_FFFF_FFFF_FFFF);
        send_word(CMD_ENC32, 64'h3FEF_FFFF_FFFF_FFFF);
        send_word(CMD_ENC16, 64'h3FEF_FFFF_FFFF_FFFF);
        send_word(CMD_ENC32, 64'hFFEF_FFFF_FFFF_FFFF);
        send_word(CMD_DEC32, 64'hFFFF_FFFF_0000_0000);
        send_word(CMD_DEC32, 64'h0000_0000_7F80_0001);
        send_word(CMD_DEC32, 64'h0000_0000_FF80_0001);
        send_word(CMD_DEC32, 64'h0000_0000_FF80_0000);
        send_word(CMD_DEC32, 64'h0000_0000_0000_0005);
        send_word(CMD_DEC32, 64'h0000_0000_8000_0080);
        send_word(CMD_DEC32, 64'hFFFF_FFFF_7FFF_FF7F);
        send_word(CMD_DEC16, 64'hFFFF_FFFF_FFFF_0000);
        send_word(CMD_DEC16, 64'h0000_0000_0000_FF81);
        send_word(CMD_DEC16, 64'h0000_0000_0000_7F80);
        send_word(CMD_DEC16, 64'h0000_0000_0000_FF80);
        send_word(CMD_DEC16, 64'h0000_0000_0000_8020);

        // Random part with a long output stall, a drain and an idle-free phase
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == 100)
                long_stall_req = 1'b1;
            if (i == 250)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (words_pending != 0)
                    @(posedge clk);
            end
            if (i == 300)
                no_idle = 1'b1;
            if (i == 400)
                no_idle = 1'b0;
            cmd = cmd_t'($urandom_range(0, 3));
            if (cmd == CMD_ENC32 || cmd == CMD_ENC16)
                send_word(cmd, rand_double());
            else
                send_word(cmd, rand_word(cmd));
        end
        in_valid <= 1'b0;

        // Drain, then let the bench idle before the verdict
        waited = 0;
        while (words_pending != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && words_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
